// ===== hw/rtl/hks_pkg.sv =====
// Package for the sorted hash key set unit.
// Holds field widths, command codes, controller states and the
// command/status structs between controller and datapath.
package hks_pkg;

  localparam int HIGH_W = 64;
  localparam int MID_W  = 64;
  localparam int LOW_W  = 32;
  localparam int KEY_W  = HIGH_W + MID_W + LOW_W;
  localparam int CAP_W  = 11;
  localparam int CNT_PORT_W = 11;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } hks_state_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic compare;
    logic shift_init;
    logic shift_step;
    logic write_key;
    logic finish;
  } hks_cmd_t;

  typedef struct packed {
    logic search_open;
    logic do_insert;
    logic shift_done;
    logic out_free;
  } hks_sts_t;

endpackage

// ===== hw/rtl/hks_ifs.sv =====
// Valid/ready channel interfaces for item and result beats.
// Depends on hks_pkg for field widths.
interface hks_in_if;
  import hks_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [HIGH_W-1:0] key_high_word;
  logic [MID_W-1:0]  key_middle_word;
  logic [LOW_W-1:0]  key_low_word;

  modport source (output valid, command, key_high_word, key_middle_word, key_low_word,
                  input ready);
  modport sink (input valid, command, key_high_word, key_middle_word, key_low_word,
                output ready);
endinterface

interface hks_out_if;
  import hks_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic                  inserted;
  logic                  full_res;
  logic [CNT_PORT_W-1:0] entry_count;

  modport source (output valid, found, inserted, full_res, entry_count, input ready);
  modport sink (input valid, found, inserted, full_res, entry_count, output ready);
endinterface

// ===== hw/rtl/hks_ctrl.sv =====
// Controller state machine: search, shift, write and result sequencing.
// Depends on hks_pkg for states and command/status structs.
module hks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hks_pkg::hks_sts_t sts,
  output hks_pkg::hks_cmd_t cmd
);
  import hks_pkg::*;

  hks_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH:  state_nxt = sts.search_open ? ST_COMPARE : ST_DECIDE;
      ST_COMPARE: state_nxt = ST_SEARCH;
      ST_DECIDE:  state_nxt = sts.do_insert ? ST_SHIFT : ST_DONE;
      ST_SHIFT:   if (sts.shift_done) state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_DONE;
      ST_DONE:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEARCH:  cmd.rd_mid     = sts.search_open;
      ST_COMPARE: cmd.compare    = 1'b1;
      ST_DECIDE:  cmd.shift_init = sts.do_insert;
      ST_SHIFT:   cmd.shift_step = 1'b1;
      ST_WRITE:   cmd.write_key  = 1'b1;
      ST_DONE:    cmd.finish     = sts.out_free;
      default:    cmd            = '0;
    endcase
  end

endmodule

// ===== hw/rtl/hks_dp.sv =====
// Datapath: key store memory, search bounds, shift pointer, count,
// capacity register and result register. Depends on hks_pkg.
module hks_dp #(
  parameter int SET_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hks_pkg::hks_cmd_t              cmd,
  output hks_pkg::hks_sts_t              sts,
  input  logic                           in_command,
  input  logic [hks_pkg::HIGH_W-1:0]     in_key_high_word,
  input  logic [hks_pkg::MID_W-1:0]      in_key_middle_word,
  input  logic [hks_pkg::LOW_W-1:0]      in_key_low_word,
  input  logic                           cfg_we,
  input  logic [hks_pkg::CAP_W-1:0]      cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic                           out_inserted,
  output logic                           out_full_res,
  output logic [hks_pkg::CNT_PORT_W-1:0] out_entry_count
);
  import hks_pkg::*;

  localparam int AW = $clog2(SET_DEPTH);
  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [KEY_W-1:0] mem [SET_DEPTH];

  logic [KEY_W-1:0]      key_r;
  logic                  cmd_r;
  logic [CW-1:0]         lo_r, hi_r, mid_r, sh_ptr_r, count_r;
  logic                  found_r, ins_r, pend_r;
  logic [AW-1:0]         wr_tgt_r;
  logic [KEY_W-1:0]      rd_data_r;
  logic [CAP_W-1:0]      cap_r;
  logic                  out_valid_r, out_found_r, out_ins_r, out_full_r;
  logic [CNT_PORT_W-1:0] out_count_r;

  logic [CW-1:0]    mid_nxt, sh_prev;
  logic             full_now, sh_more;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;

  assign mid_nxt  = lo_r + ((hi_r - lo_r) >> 1);
  assign sh_prev  = sh_ptr_r - CW'(1);
  assign sh_more  = sh_ptr_r > lo_r;
  assign full_now = (MW'(count_r) >= MW'(cap_r)) || (count_r >= CW'(SET_DEPTH));

  assign rd_en   = cmd.rd_mid || (cmd.shift_step && sh_more);
  assign rd_addr = cmd.rd_mid ? mid_nxt[AW-1:0] : sh_prev[AW-1:0];
  assign wr_en   = cmd.write_key || (cmd.shift_step && pend_r);
  assign wr_addr = cmd.write_key ? lo_r[AW-1:0] : wr_tgt_r;
  assign wr_data = cmd.write_key ? key_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= {in_key_high_word, in_key_middle_word, in_key_low_word};
      cmd_r   <= in_command;
      lo_r    <= '0;
      hi_r    <= count_r;
      found_r <= 1'b0;
      ins_r   <= 1'b0;
    end
    if (cmd.rd_mid) mid_r <= mid_nxt;
    if (cmd.compare) begin
      if (rd_data_r < key_r) begin
        lo_r <= mid_r + CW'(1);
      end else begin
        hi_r <= mid_r;
        if (rd_data_r == key_r) found_r <= 1'b1;
      end
    end
    if (cmd.shift_init) begin
      sh_ptr_r <= count_r;
      pend_r   <= 1'b0;
    end
    if (cmd.shift_step) begin
      pend_r <= sh_more;
      if (sh_more) begin
        sh_ptr_r <= sh_prev;
        wr_tgt_r <= sh_ptr_r[AW-1:0];
      end
    end
    if (cmd.write_key) ins_r <= 1'b1;
    if (cmd.finish) begin
      out_found_r <= found_r;
      out_ins_r   <= ins_r;
      out_full_r  <= (cmd_r == CMD_INSERT) && !ins_r && full_now;
      out_count_r <= CNT_PORT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write_key) count_r <= count_r + CW'(1);
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.search_open = lo_r < hi_r;
  assign sts.do_insert   = (cmd_r == CMD_INSERT) && !found_r && !full_now;
  assign sts.shift_done  = (sh_ptr_r == lo_r) && !pend_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_inserted    = out_ins_r;
  assign out_full_res    = out_full_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== hw/rtl/sorted_hash_key_set_unit.sv =====
// Sorted hash key set: binary search with in-place insertion shift.
// One beat in flight at a time; the single-port-read key memory sets both the
// search (read then compare per step) and the shift (one entry per cycle).
// Synchronous active-low reset: count 0, capacity 1024; store contents undefined.
module sorted_hash_key_set_unit #(
  parameter int SET_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  hks_in_if.sink                    in_bus,
  hks_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [hks_pkg::CAP_W-1:0] cfg_wdata
);
  import hks_pkg::*;

  hks_cmd_t cmd;
  hks_sts_t sts;

  hks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hks_dp #(
    .SET_DEPTH (SET_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_bus.command),
    .in_key_high_word   (in_bus.key_high_word),
    .in_key_middle_word (in_bus.key_middle_word),
    .in_key_low_word    (in_bus.key_low_word),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_bus.valid),
    .out_ready          (out_bus.ready),
    .out_found          (out_bus.found),
    .out_inserted       (out_bus.inserted),
    .out_full_res       (out_bus.full_res),
    .out_entry_count    (out_bus.entry_count)
  );

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !(out_bus.inserted && (out_bus.full_res || out_bus.found)))
    else $error("result beat reports conflicting outcomes");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("new beat accepted while previous item in work");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.inserted) |-> (out_bus.entry_count != '0))
    else $error("inserted key but entry count is zero");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_key |-> $past(cmd.shift_step) && $past(sts.shift_done))
    else $error("key written before shift completed");

endmodule

// ===== bench/tb_sorted_hash_key_set_unit.sv =====
// Testbench for sorted_hash_key_set_unit: lookups, inserts, duplicates and capacity refusals,
// checked beat by beat against a sorted-queue predictor under random stalls on both channels.
// Depends on hks_pkg, hks_ifs.sv and the unit's RTL.
module tb_sorted_hash_key_set_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hks_pkg::*;

  localparam int          DEPTH       = 1024;
  localparam int          CLK_PERIOD  = 12;
  localparam int          SETTLE      = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef logic [KEY_W-1:0] hash_key_t;

  typedef struct packed {
    logic                  found;
    logic                  inserted;
    logic                  full_res;
    logic [CNT_PORT_W-1:0] entry_count;
  } set_status_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  hks_in_if  in_bus ();
  hks_out_if out_bus ();

  sorted_hash_key_set_unit #(.SET_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hash_key_t   held_keys[$];
  int unsigned capacity_reg;
  set_status_t pending_status[$];
  int unsigned errors, cycle_count;
  int unsigned lookups_sent, keys_added, duplicates, refusals;
  bit          idle_on;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit hit with %0d results outstanding",
               $time, pending_status.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side backpressure: random bursts of stalled cycles, separated by quiet stretches
  initial begin : ready_driver
    int unsigned stall_left, quiet_left;
    stall_left = 0;
    quiet_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
        quiet_left = $urandom_range(0, 40);
      end else begin
        out_bus.ready <= 1'b1;
        if (quiet_left > 0) quiet_left--;
      end
    end
  end

  // lower-bound search over the held keys, then insert in place for a new key when there is room
  function automatic set_status_t apply_item(logic cmd, hash_key_t key);
    set_status_t st;
    int unsigned lo, hi, mid, held, cap;
    st   = '0;
    held = held_keys.size();
    cap  = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    lo   = 0;
    hi   = held;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        if (held_keys[mid] == key) st.found = 1'b1;
        hi = mid;
      end
    end
    if (cmd == CMD_INSERT) begin
      if (held >= cap) begin
        st.full_res = 1'b1;
      end else if (!st.found) begin
        held_keys.insert(lo, key);
        st.inserted = 1'b1;
      end
    end
    st.entry_count = CNT_PORT_W'(held_keys.size());
    return st;
  endfunction

  function automatic void check_field(string name, logic [CNT_PORT_W-1:0] want,
                                      logic [CNT_PORT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    set_status_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got found=%0b inserted=%0b %s",
                 $time, out_bus.found, out_bus.inserted,
                 $sformatf("full_res=%0b entry_count=%0d", out_bus.full_res,
                           out_bus.entry_count));
        errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("found", CNT_PORT_W'(want.found), CNT_PORT_W'(out_bus.found));
        check_field("inserted", CNT_PORT_W'(want.inserted), CNT_PORT_W'(out_bus.inserted));
        check_field("full_res", CNT_PORT_W'(want.full_res), CNT_PORT_W'(out_bus.full_res));
        check_field("entry_count", want.entry_count, out_bus.entry_count);
      end
    end
  end

  // valid stays high across back-to-back beats; it only drops for a gap or a drain
  task automatic send_item(logic cmd, hash_key_t key);
    set_status_t st;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    {in_bus.key_high_word, in_bus.key_middle_word, in_bus.key_low_word} <= key;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    st = apply_item(cmd, key);
    pending_status.push_back(st);
    if (cmd == CMD_LOOKUP) lookups_sent++;
    else if (st.inserted) keys_added++;
    else if (st.full_res) refusals++;
    else duplicates++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_capacity(int unsigned value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CAP_W-1:0];
    @(negedge clk);
    cfg_we       <= 1'b0;
    capacity_reg = value;
  endtask

  function automatic hash_key_t random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // mix of held keys, close neighbors of held keys, extremes and fresh random keys
  function automatic hash_key_t pick_key();
    hash_key_t   k;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    k   = random_key();
    if (held_keys.size() != 0 && sel < 30) begin
      k = held_keys[$urandom_range(0, held_keys.size() - 1)];
    end else if (held_keys.size() != 0 && sel < 50) begin
      k = held_keys[$urandom_range(0, held_keys.size() - 1)];
      case ($urandom_range(0, 2))
        0: k[LOW_W-1:0] = k[LOW_W-1:0] + 32'd1;
        1: k[LOW_W-1:0] = k[LOW_W-1:0] - 32'd1;
        default: k[LOW_W +: MID_W] = {$urandom, $urandom};
      endcase
    end else if (sel < 60) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k[KEY_W-1 -: HIGH_W] = '0;
        default: k[KEY_W-1 -: HIGH_W] = '1;
      endcase
    end
    return k;
  endfunction

  task automatic run_random(int unsigned count, int unsigned insert_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP, pick_key());
    end
  endtask

  task automatic test_empty_set();
    send_item(CMD_LOOKUP, '0);
    send_item(CMD_LOOKUP, '1);
  endtask

  task automatic test_capacity_zero();
    set_capacity(0);
    send_item(CMD_INSERT, '1);
    send_item(CMD_LOOKUP, '1);
    set_capacity(2047);
  endtask

  task automatic test_key_extremes();
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, '1);
    send_item(CMD_INSERT, {64'h1, 64'h0, 32'h0});
    send_item(CMD_INSERT, {64'h0, 64'h0, 32'h1});
    send_item(CMD_INSERT, {64'h0, 64'h1, 32'h0});
    send_item(CMD_INSERT, {64'h8000_0000_0000_0000, 64'h0, 32'h0});
    send_item(CMD_INSERT, '1);
    send_item(CMD_LOOKUP, '0);
    send_item(CMD_LOOKUP, {64'h0, 64'h0, 32'h2});
  endtask

  task automatic test_capacity_edges();
    set_capacity(held_keys.size() + 1);
    send_item(CMD_INSERT, random_key());
    send_item(CMD_INSERT, random_key());
    send_item(CMD_INSERT, '0);
    send_item(CMD_LOOKUP, '1);
    // lowered below the held count: inserts refused, lookups still hit
    set_capacity(2);
    send_item(CMD_INSERT, random_key());
    send_item(CMD_LOOKUP, {64'h1, 64'h0, 32'h0});
  endtask

  task automatic test_random_mixed();
    set_capacity(1024);
    run_random(75, 60);
    drain_results();
    run_random(75, 60);
  endtask

  task automatic test_random_near_full();
    set_capacity(held_keys.size() + 20);
    run_random(120, 80);
  endtask

  task automatic test_random_unthrottled();
    set_capacity(2047);
    run_random(70, 60);
    idle_on = 1'b0;
    run_random(60, 60);
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_bus.valid           = 1'b0;
    in_bus.command         = CMD_LOOKUP;
    in_bus.key_high_word   = '0;
    in_bus.key_middle_word = '0;
    in_bus.key_low_word    = '0;
    capacity_reg           = 1024;
    idle_on                = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_set();
    test_capacity_zero();
    test_key_extremes();
    test_capacity_edges();
    test_random_mixed();
    test_random_near_full();
    test_random_unthrottled();

    drain_results();
    repeat (DEPTH + 64) @(posedge clk);

    $display("Covered %0d lookups, %0d new keys, %0d duplicate inserts, %0d refused inserts",
             lookups_sent, keys_added, duplicates, refusals);
    $display("Capacity settings 0, 2, 1024, 2047 and near-count; %0d keys held at the end",
             held_keys.size());
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
